// ----- hdl/sbpb_pkg.sv -----
// ----------------------------------------------------------------------------
// sbpb_pkg
// Shared constants, types and helpers for the spectrum band peak bar graph.
// ----------------------------------------------------------------------------
package sbpb_pkg;

  localparam int FRAME_BINS  = 1024;
  localparam int BAR_COLUMNS = 8;
  localparam int SAMPLE_BITS = 24;

  localparam int BIN_W   = $clog2(FRAME_BINS);
  localparam logic [BIN_W-1:0] POS_MAX = BIN_W'(FRAME_BINS - 1);

  localparam int EDGE_W      = 10;
  localparam int LOWER_EDGES = 5;
  localparam logic [EDGE_W-1:0] EDGE_LIMIT = EDGE_W'(512);

  localparam int LOWER_W   = 50;
  localparam int UPPER_W   = 40;
  localparam int STEP_W    = 16;
  localparam int CFG_W     = 50;
  localparam int CFG_IDX_W = 2;

  localparam int POWER_W  = 2 * SAMPLE_BITS;
  localparam int BAR_ROWS = 8;
  localparam int ROW_W    = $clog2(BAR_ROWS);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(BAR_ROWS - 1);
  localparam int SEG_W    = STEP_W + $clog2(BAR_ROWS + 1);
  localparam int THR_W    = 2 * SEG_W;

  localparam logic [LOWER_W-1:0] EDGES_LOWER_RST = LOWER_W'(64'd25298434262016);
  localparam logic [UPPER_W-1:0] EDGES_UPPER_RST = UPPER_W'(64'd298743615543);
  localparam logic [STEP_W-1:0]  HEIGHT_STEP_RST = STEP_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGES_LOWER = 2'd0,
    REG_EDGES_UPPER = 2'd1,
    REG_HEIGHT_STEP = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [LOWER_W-1:0] edges_lower;
    logic [UPPER_W-1:0] edges_upper;
    logic [STEP_W-1:0]  height_step;
  } cfg_t;

  // one squared bin on its way to the peak registers
  typedef struct packed {
    logic                   valid;
    logic                   last;
    logic [BAR_COLUMNS-1:0] match;
    logic [POWER_W-1:0]     re_sq;
    logic [POWER_W-1:0]     im_sq;
  } bin_t;

  typedef logic [BAR_COLUMNS-1:0][POWER_W-1:0] peak_arr_t;
  typedef logic [BAR_ROWS-1:0][BAR_COLUMNS-1:0] mask_arr_t;

  function automatic logic [EDGE_W-1:0] edge_at(cfg_t cfg, int unsigned i);
    logic [EDGE_W-1:0] e;
    if (i < LOWER_EDGES) begin
      e = cfg.edges_lower[EDGE_W*i +: EDGE_W];
    end else begin
      e = cfg.edges_upper[EDGE_W*(i-LOWER_EDGES) +: EDGE_W];
    end
    return (e > EDGE_LIMIT) ? EDGE_LIMIT : e;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] abs_mag(logic [SAMPLE_BITS-1:0] x);
    return x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

// ----- hdl/spectrum_band_peak_bargraph.sv -----
// ----------------------------------------------------------------------------
// spectrum_band_peak_bargraph
// Peak-hold bar graph over eight spectrum bands, emitted as row bytes.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  in        in   in_valid_i/in_stall_o    real_part_i, imag_part_i, last_bin_i
//  out       out  out_valid_o/out_stall_i  row_index_o, row_bits_o, last_row_o
//  cfg       in   cfg_we_i                 cfg_index_i, cfg_data_i
//
//  One bin per cycle while in_stall_o is low. Path: input reg, square reg, peak
//  reg, snapshot, row reg; after the last bin is taken, 8 rows follow.
//  Reset clears peaks, bin counter and all valids; no clearing pass.
//  in_stall_o rises only when a frame end reaches the peak stage while the
//  previous frame's snapshot is still waiting on the row register.
// ----------------------------------------------------------------------------
module spectrum_band_peak_bargraph (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [sbpb_pkg::SAMPLE_BITS-1:0] real_part_i,
  input  logic signed [sbpb_pkg::SAMPLE_BITS-1:0] imag_part_i,
  input  logic                                    last_bin_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [sbpb_pkg::ROW_W-1:0]              row_index_o,
  output logic [sbpb_pkg::BAR_COLUMNS-1:0]        row_bits_o,
  output logic                                    last_row_o,
  input  logic                                    cfg_we_i,
  input  logic [sbpb_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [sbpb_pkg::CFG_W-1:0]              cfg_data_i
);

  sbpb_pkg::cfg_t      cfg_d, cfg_q;
  sbpb_pkg::bin_t      bin;
  sbpb_pkg::peak_arr_t snap_peak;
  logic                adv;
  logic                snap_valid;
  logic                take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (sbpb_pkg::cfg_reg_e'(cfg_index_i))
        sbpb_pkg::REG_EDGES_LOWER: begin
          cfg_d.edges_lower = cfg_data_i[sbpb_pkg::LOWER_W-1:0];
        end
        sbpb_pkg::REG_EDGES_UPPER: begin
          cfg_d.edges_upper = cfg_data_i[sbpb_pkg::UPPER_W-1:0];
        end
        sbpb_pkg::REG_HEIGHT_STEP: begin
          cfg_d.height_step = cfg_data_i[sbpb_pkg::STEP_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.edges_lower <= sbpb_pkg::EDGES_LOWER_RST;
      cfg_q.edges_upper <= sbpb_pkg::EDGES_UPPER_RST;
      cfg_q.height_step <= sbpb_pkg::HEIGHT_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = !adv;

  sbpb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .last_bin_i  (last_bin_i),
    .cfg_i       (cfg_q),
    .bin_o       (bin)
  );

  sbpb_peak u_peak (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bin_i        (bin),
    .take_i       (take),
    .adv_o        (adv),
    .snap_valid_o (snap_valid),
    .snap_peak_o  (snap_peak)
  );

  sbpb_rows u_rows (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .height_step_i (cfg_q.height_step),
    .snap_valid_i  (snap_valid),
    .snap_peak_i   (snap_peak),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_index_o   (row_index_o),
    .row_bits_o    (row_bits_o),
    .last_row_o    (last_row_o)
  );

endmodule

// ----- hdl/sbpb_front.sv -----
// ----------------------------------------------------------------------------
// sbpb_front
// Input register, bin counter, magnitude squares and band match.
// ----------------------------------------------------------------------------
module sbpb_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 in_valid_i,
  input  logic signed [sbpb_pkg::SAMPLE_BITS-1:0] real_part_i,
  input  logic signed [sbpb_pkg::SAMPLE_BITS-1:0] imag_part_i,
  input  logic                                 last_bin_i,
  input  sbpb_pkg::cfg_t                       cfg_i,
  output sbpb_pkg::bin_t                       bin_o
);

  logic                            accept;
  logic [sbpb_pkg::BIN_W-1:0]      pos_d, pos_q;
  logic                            s0_valid_d, s0_valid_q;
  logic [sbpb_pkg::SAMPLE_BITS-1:0] s0_re_q, s0_im_q;
  logic                            s0_last_q;
  logic [sbpb_pkg::BIN_W-1:0]      s0_pos_q;
  logic [sbpb_pkg::SAMPLE_BITS-1:0] mag_re, mag_im;
  sbpb_pkg::bin_t                  bin_d, bin_q;

  assign accept = in_valid_i && adv_i;

  always_comb begin
    pos_d = pos_q;
    priority if (accept && last_bin_i) begin
      pos_d = '0;
    end else if (accept && (pos_q != sbpb_pkg::POS_MAX)) begin
      pos_d = pos_q + 1'b1;
    end
  end

  assign s0_valid_d = adv_i ? in_valid_i : s0_valid_q;

  assign mag_re = sbpb_pkg::abs_mag(s0_re_q);
  assign mag_im = sbpb_pkg::abs_mag(s0_im_q);

  always_comb begin
    bin_d = bin_q;
    if (adv_i) begin
      bin_d.valid = s0_valid_q;
      bin_d.last  = s0_last_q;
      bin_d.re_sq = mag_re * mag_re;
      bin_d.im_sq = mag_im * mag_im;
      for (int unsigned c = 0; c < sbpb_pkg::BAR_COLUMNS; c++) begin
        bin_d.match[c] = (s0_pos_q >= sbpb_pkg::edge_at(cfg_i, c)) &&
                         (s0_pos_q <  sbpb_pkg::edge_at(cfg_i, c + 1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s0_valid_q <= 1'b0;
      bin_q      <= '0;
    end else begin
      pos_q      <= pos_d;
      s0_valid_q <= s0_valid_d;
      bin_q      <= bin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_re_q   <= real_part_i;
      s0_im_q   <= imag_part_i;
      s0_last_q <= last_bin_i;
      s0_pos_q  <= pos_q;
    end
  end

  assign bin_o = bin_q;

endmodule

// ----- hdl/sbpb_peak.sv -----
// ----------------------------------------------------------------------------
// sbpb_peak
// Per-column peak registers and the frame snapshot taken on the last bin.
// ----------------------------------------------------------------------------
module sbpb_peak (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbpb_pkg::bin_t       bin_i,
  input  logic                 take_i,
  output logic                 adv_o,
  output logic                 snap_valid_o,
  output sbpb_pkg::peak_arr_t  snap_peak_o
);

  logic [sbpb_pkg::POWER_W-1:0] power;
  logic                         consume;
  sbpb_pkg::peak_arr_t          upd, peak_d, peak_q, snap_peak_q;
  logic                         snap_valid_d, snap_valid_q;

  assign power = bin_i.re_sq + bin_i.im_sq;

  // hold the pipe only when a frame end finds the snapshot still occupied
  assign adv_o   = !(bin_i.valid && bin_i.last && snap_valid_q && !take_i);
  assign consume = bin_i.valid && adv_o;

  always_comb begin
    for (int c = 0; c < sbpb_pkg::BAR_COLUMNS; c++) begin
      upd[c] = (bin_i.match[c] && (power > peak_q[c])) ? power : peak_q[c];
    end
  end

  always_comb begin
    peak_d = peak_q;
    if (consume) begin
      peak_d = bin_i.last ? '0 : upd;
    end
  end

  always_comb begin
    snap_valid_d = snap_valid_q && !take_i;
    if (consume && bin_i.last) begin
      snap_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q       <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      peak_q       <= peak_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && bin_i.last) begin
      snap_peak_q <= upd;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_peak_o  = snap_peak_q;

endmodule

// ----- hdl/sbpb_rows.sv -----
// ----------------------------------------------------------------------------
// sbpb_rows
// Height thresholds, bar masks and the eight-row output register.
// ----------------------------------------------------------------------------
module sbpb_rows (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [sbpb_pkg::STEP_W-1:0]       height_step_i,
  input  logic                              snap_valid_i,
  input  sbpb_pkg::peak_arr_t               snap_peak_i,
  output logic                              take_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sbpb_pkg::ROW_W-1:0]        row_index_o,
  output logic [sbpb_pkg::BAR_COLUMNS-1:0]  row_bits_o,
  output logic                              last_row_o
);

  logic [sbpb_pkg::SEG_W-1:0] seg [sbpb_pkg::BAR_ROWS];
  logic [sbpb_pkg::THR_W-1:0] thr_q [sbpb_pkg::BAR_ROWS];
  sbpb_pkg::mask_arr_t        mask_d, mask_q;
  logic                       ovalid_d, ovalid_q;
  logic [sbpb_pkg::ROW_W-1:0] row_d, row_q;
  logic                       is_last;
  logic                       out_free;

  // row r lights when peak >= ((r+1)*step)^2
  always_comb begin
    for (int r = 0; r < sbpb_pkg::BAR_ROWS; r++) begin
      seg[r] = sbpb_pkg::SEG_W'(r + 1) * sbpb_pkg::SEG_W'(height_step_i);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < sbpb_pkg::BAR_ROWS; r++) begin
      thr_q[r] <= seg[r] * seg[r];
    end
  end

  always_comb begin
    for (int r = 0; r < sbpb_pkg::BAR_ROWS; r++) begin
      for (int c = 0; c < sbpb_pkg::BAR_COLUMNS; c++) begin
        mask_d[r][c] = (sbpb_pkg::POWER_W'(thr_q[r]) <= snap_peak_i[c]);
      end
    end
  end

  assign is_last  = (row_q == sbpb_pkg::LAST_ROW);
  assign out_free = !ovalid_q || (!out_stall_i && is_last);
  assign take_o   = snap_valid_i && out_free;

  always_comb begin
    ovalid_d = ovalid_q;
    row_d    = row_q;
    priority if (take_o) begin
      ovalid_d = 1'b1;
      row_d    = '0;
    end else if (ovalid_q && !out_stall_i) begin
      if (is_last) begin
        ovalid_d = 1'b0;
      end else begin
        row_d = row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      row_q    <= '0;
    end else begin
      ovalid_q <= ovalid_d;
      row_q    <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      mask_q <= mask_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign row_index_o = row_q;
  assign row_bits_o  = mask_q[row_q];
  assign last_row_o  = is_last;

endmodule

// ----- hdl/sbpb_checker.sv -----
// ----------------------------------------------------------------------------
// sbpb_checker
// Port-level checks on the row output sequence of the bar graph block.
// ----------------------------------------------------------------------------
module sbpb_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    out_valid_o,
  input logic                                    out_stall_i,
  input logic [sbpb_pkg::ROW_W-1:0]              row_index_o,
  input logic [sbpb_pkg::BAR_COLUMNS-1:0]        row_bits_o,
  input logic                                    last_row_o
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(row_index_o) && $stable(row_bits_o))
    else $error("stalled output word changed");

  // rows of a frame follow without gaps, in order
  a_row_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_row_o |=>
      out_valid_o && (row_index_o == $past(row_index_o) + 1'b1))
    else $error("row sequence broken");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_row_o == (row_index_o == sbpb_pkg::LAST_ROW)))
    else $error("last_row flag not on the top row");

  // a frame that follows an idle output opens at the bottom row
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> (row_index_o == '0))
    else $error("frame did not start at row 0");

endmodule

bind spectrum_band_peak_bargraph sbpb_checker u_sbpb_checker (.*);

// ----- tb/tb_spectrum_band_peak_bargraph.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectrum_band_peak_bargraph
// Streams FFT bins into the bar graph block and checks every row word against
// a band peak predictor kept in the testbench. Covers register extremes, edge
// saturation, zero step and mid-frame edge changes, with random idling on the
// input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_spectrum_band_peak_bargraph;
  import sbpb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned RANDOM_BINS    = 380;

  localparam logic [LOWER_W-1:0] LOWER_AT_RESET = 50'd25298434262016;
  localparam logic [UPPER_W-1:0] UPPER_AT_RESET = 40'd298743615543;
  localparam logic [STEP_W-1:0]  STEP_AT_RESET  = 16'd100;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef logic [8:0][EDGE_W-1:0] edge_plan_t;

  typedef struct packed {
    logic [ROW_W-1:0]       row_num;
    logic [BAR_COLUMNS-1:0] bits;
    logic                   top;
  } row_word_t;

  class bargraph_scoreboard;
    logic [LOWER_W-1:0] edges_lower;
    logic [UPPER_W-1:0] edges_upper;
    logic [STEP_W-1:0]  step;
    logic [POWER_W-1:0] peak [BAR_COLUMNS];
    int unsigned        bin_pos;
    row_word_t          rows_due [$];
    int unsigned        errors;

    function new();
      edges_lower = LOWER_AT_RESET;
      edges_upper = UPPER_AT_RESET;
      step        = STEP_AT_RESET;
      foreach (peak[c]) peak[c] = '0;
      bin_pos = 0;
      errors  = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_EDGES_LOWER: edges_lower = data[LOWER_W-1:0];
        REG_EDGES_UPPER: edges_upper = data[UPPER_W-1:0];
        REG_HEIGHT_STEP: step = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // bin index bound i, edges past 512 pinned at 512
    function int unsigned band_edge(int unsigned i);
      logic [EDGE_W-1:0] e;
      if (i < 5) e = EDGE_W'(edges_lower >> (EDGE_W * i));
      else e = EDGE_W'(edges_upper >> (EDGE_W * (i - 5)));
      return (e > 10'd512) ? 512 : int'(e);
    endfunction

    function int unsigned pending();
      return rows_due.size();
    endfunction

    function void note_bin(logic signed [SAMPLE_BITS-1:0] re,
                           logic signed [SAMPLE_BITS-1:0] im, logic is_last);
      longint             a;
      longint             b;
      longint             t;
      logic [POWER_W-1:0] power;
      int unsigned        hgt [BAR_COLUMNS];
      int unsigned        c;
      int unsigned        k;
      int unsigned        r;
      row_word_t          w;
      a = re;
      b = im;
      if (a < 0) a = -a;
      if (b < 0) b = -b;
      power = POWER_W'(a * a + b * b);
      for (c = 0; c < BAR_COLUMNS; c++) begin
        if (bin_pos >= band_edge(c) && bin_pos < band_edge(c + 1) && power > peak[c])
          peak[c] = power;
      end
      if (!is_last) begin
        if (bin_pos < FRAME_BINS - 1) bin_pos++;
        return;
      end
      // largest h with (h*step)^2 <= peak, capped at 8
      for (c = 0; c < BAR_COLUMNS; c++) begin
        hgt[c] = 0;
        for (k = 1; k <= 8; k++) begin
          t = longint'(k) * longint'(step);
          if (t * t <= longint'(peak[c])) hgt[c] = k;
        end
      end
      for (r = 0; r < BAR_ROWS; r++) begin
        w.row_num = ROW_W'(r);
        w.bits    = '0;
        for (c = 0; c < BAR_COLUMNS; c++) w.bits[c] = (hgt[c] > r);
        w.top = (r == BAR_ROWS - 1);
        rows_due.push_back(w);
      end
      foreach (peak[i]) peak[i] = '0;
      bin_pos = 0;
    endfunction

    function void check_row(logic [ROW_W-1:0] row_num, logic [BAR_COLUMNS-1:0] bits,
                            logic top);
      row_word_t w;
      if (rows_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected row word: index %0d bits %02h last %0b",
                 $time, row_num, bits, top);
        return;
      end
      w = rows_due.pop_front();
      if (row_num !== w.row_num) begin
        errors++;
        $display("%0t: row_index expected %0d got %0d", $time, w.row_num, row_num);
      end
      if (bits !== w.bits) begin
        errors++;
        $display("%0t: row_bits (row %0d) expected %02h got %02h",
                 $time, w.row_num, w.bits, bits);
      end
      if (top !== w.top) begin
        errors++;
        $display("%0t: last_row (row %0d) expected %0b got %0b",
                 $time, w.row_num, w.top, top);
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] real_part_i;
  logic signed [SAMPLE_BITS-1:0] imag_part_i;
  logic                          last_bin_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [ROW_W-1:0]              row_index_o;
  logic [BAR_COLUMNS-1:0]        row_bits_o;
  logic                          last_row_o;
  logic                          cfg_we_i;
  logic [CFG_IDX_W-1:0]          cfg_index_i;
  logic [CFG_W-1:0]              cfg_data_i;

  bargraph_scoreboard sb;
  logic [STEP_W-1:0]  cur_step;
  bit                 tx_calm;
  bit                 rx_calm;
  int unsigned        rx_hold;
  int unsigned        quiet_cycles;

  spectrum_band_peak_bargraph dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .last_bin_i  (last_bin_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_index_o (row_index_o),
    .row_bits_o  (row_bits_o),
    .last_row_o  (last_row_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // output side: stall bursts, mostly short, with calm stretches
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) rx_calm <= !rx_calm;
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_calm || $urandom_range(0, 3) != 0) begin
      out_stall_i <= 1'b0;
      rx_hold     <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b1;
      rx_hold     <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_row(row_index_o, row_bits_o, last_row_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    int unsigned lim;
    int unsigned pick;
    int          v;
    lim  = (cur_step == 0) ? 1000 : 9 * int'(cur_step);
    pick = $urandom_range(0, 15);
    if (pick == 0) return SAMPLE_BITS'($urandom);
    if (pick == 1) return ($urandom_range(0, 1) != 0) ? SAMPLE_MIN : SAMPLE_MAX;
    v = int'($urandom_range(0, lim));
    if ($urandom_range(0, 1) != 0) v = -v;
    return SAMPLE_BITS'(v);
  endfunction

  task automatic send_bin(input logic signed [SAMPLE_BITS-1:0] re,
                          input logic signed [SAMPLE_BITS-1:0] im, input logic is_last);
    int unsigned gap;
    int unsigned pick;
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (!tx_calm) begin
      if (pick < 5) gap = $urandom_range(8, 40);
      else if (pick < 30) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    real_part_i <= re;
    imag_part_i <= im;
    last_bin_i  <= is_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_bin(re, im, is_last);
  endtask

  // hold the input until every row has left and the pipe is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_block(input edge_plan_t plan, input logic [STEP_W-1:0] step);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_EDGES_LOWER;
    cfg_data_i  <= CFG_W'(plan[4:0]);
    sb.set_reg(REG_EDGES_LOWER, CFG_W'(plan[4:0]));
    @(posedge clk_i);
    cfg_index_i <= REG_EDGES_UPPER;
    cfg_data_i  <= CFG_W'(plan[8:5]);
    sb.set_reg(REG_EDGES_UPPER, CFG_W'(plan[8:5]));
    @(posedge clk_i);
    cfg_index_i <= REG_HEIGHT_STEP;
    cfg_data_i  <= CFG_W'(step);
    sb.set_reg(REG_HEIGHT_STEP, CFG_W'(step));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_step = step;
  endtask

  initial begin
    edge_plan_t                    plan;
    logic [STEP_W-1:0]             step;
    int unsigned                   rand_bins;
    int unsigned                   frame_len;
    int unsigned                   pick;
    int unsigned                   at;
    int                            n;
    sb           = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    real_part_i  = '0;
    imag_part_i  = '0;
    last_bin_i   = 1'b0;
    out_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = REG_EDGES_LOWER;
    cfg_data_i   = '0;
    cur_step     = STEP_AT_RESET;
    tx_calm      = 1'b1;
    rx_calm      = 1'b0;
    rx_hold      = 0;
    quiet_cycles = 0;
    rand_bins    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset bands: full-scale bins in the two lowest columns, 500 in the third
    send_bin(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_bin(SAMPLE_MAX, '0, 1'b0);
    send_bin('0, SAMPLE_MAX, 1'b0);
    send_bin(SAMPLE_BITS'(300), SAMPLE_BITS'(-400), 1'b0);
    send_bin('0, '0, 1'b0);
    send_bin(SAMPLE_BITS'(-1), SAMPLE_BITS'(1), 1'b1);
    tx_calm = 1'b0;
    // one segment boundary: 99 stays empty, 100 lights one segment
    send_bin(SAMPLE_BITS'(99), '0, 1'b0);
    send_bin(SAMPLE_BITS'(60), SAMPLE_BITS'(80), 1'b1);
    settle();

    // all edges saturated, zero step: every bar full
    program_block('1, '0);
    repeat (3) send_bin(random_sample(), random_sample(), 1'b0);
    send_bin(random_sample(), random_sample(), 1'b1);
    settle();

    // one bin per column, heights 0..7 at the largest step
    for (n = 0; n < 9; n++) plan[n] = EDGE_W'(n);
    program_block(plan, '1);
    for (n = 0; n < 8; n++)
      send_bin(SAMPLE_BITS'((n % 2 == 1) ? -(n * 65535) : n * 65535), '0, n == 7);

    while (rand_bins < RANDOM_BINS) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 9);
        at   = $urandom_range(0, 4);
        for (n = 0; n < 9; n++) begin
          if (pick == 0) begin
            plan[n] = EDGE_W'($urandom_range(0, 1023));
          end else if (pick == 1) begin
            plan[n] = '1;
          end else if (pick == 2) begin
            plan[n] = '0;
          end else if ($urandom_range(0, 19) == 0) begin
            plan[n] = EDGE_W'($urandom_range(513, 1023));
          end else begin
            plan[n] = EDGE_W'(at);
            at = at + $urandom_range(0, 10);
          end
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) step = '0;
        else if (pick == 1) step = '1;
        else if (pick == 2) step = STEP_W'($urandom_range(1, 65535));
        else if (pick == 3) step = STEP_W'($urandom_range(1, 20));
        else step = STEP_W'($urandom_range(20, 3000));
        program_block(plan, step);
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 19);
        if (pick < 16) frame_len = $urandom_range(1, 60);
        else if (pick < 19) frame_len = $urandom_range(61, 150);
        else frame_len = $urandom_range(151, 700);
        for (n = 1; n <= frame_len; n++) begin
          send_bin(random_sample(), random_sample(), n == frame_len);
          rand_bins++;
        end
      end
      // leave a frame open so the next register write lands mid-frame
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 30)) begin
          send_bin(random_sample(), random_sample(), 1'b0);
          rand_bins++;
        end
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
